@@ hw/rtl/cbvt_pkg.sv @@
package cbvt_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_MINUTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_SECONDS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_STYLE    = 2'd2;
    localparam int unsigned CFG_DATA_W = 8;

    // run modes
    localparam logic [1:0] MODE_RUNNING = 2'd2;
    localparam logic [1:0] MODE_MANUAL  = 2'd3;

    // unit styles without continuous blowdown
    localparam logic [1:0] STYLE_NO_CBD_A = 2'd1;
    localparam logic [1:0] STYLE_NO_CBD_B = 2'd3;

    localparam int unsigned WORK_W  = 16;
    localparam int unsigned TENTH_W = 12;
    localparam int unsigned THR_W   = 14;   // 255*60 fits
    localparam logic [WORK_W-1:0] WORK_MAX = '1;
    localparam logic [THR_W-1:0]   SECONDS_PER_MINUTE = 14'd60;
    localparam logic [TENTH_W-1:0] TENTHS_PER_SECOND  = 12'd10;

    typedef struct packed {
        logic [1:0] run_mode;
        logic       flame_on;
        logic       second_pulse;
        logic       tenth_pulse;
        logic       pump_running;
    } cbvt_item_t;

    typedef struct packed {
        logic valve_open;
        logic burst_active;
    } cbvt_result_t;

    typedef struct packed {
        logic [7:0] delay_minutes;
        logic [7:0] open_seconds;
        logic [1:0] unit_style;
    } cbvt_cfg_t;

endpackage

@@ hw/rtl/cbvt_if.sv @@
interface cbvt_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] run_mode;
    logic       flame_on;
    logic       second_pulse;
    logic       tenth_pulse;
    logic       pump_running;

    modport source (output valid, output run_mode, output flame_on, output second_pulse,
                    output tenth_pulse, output pump_running, input ready);
    modport sink   (input valid, input run_mode, input flame_on, input second_pulse,
                    input tenth_pulse, input pump_running, output ready);
endinterface

interface cbvt_result_if;
    logic valid;
    logic ready;
    logic valve_open;
    logic burst_active;

    modport source (output valid, output valve_open, output burst_active, input ready);
    modport sink   (input valid, input valve_open, input burst_active, output ready);
endinterface

interface cbvt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/cbvt_cfg_regs.sv @@
module cbvt_cfg_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [1:0]               wr_index,
    input  logic [7:0]               wr_data,
    output cbvt_pkg::cbvt_cfg_t      cfg
);
    import cbvt_pkg::*;

    cbvt_cfg_t cfg_reg;
    cbvt_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_DELAY_MINUTES: cfg_next.delay_minutes = wr_data;
                REG_OPEN_SECONDS:  cfg_next.open_seconds  = wr_data;
                REG_UNIT_STYLE:    cfg_next.unit_style    = wr_data[1:0];
                default:           cfg_next = cfg_reg;   // unused index, dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/cbvt_core.sv @@
module cbvt_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  cbvt_pkg::cbvt_item_t   item,
    input  cbvt_pkg::cbvt_cfg_t    cfg,
    output cbvt_pkg::cbvt_result_t result
);
    import cbvt_pkg::*;

    logic [WORK_W-1:0]  work_seconds_reg,   work_seconds_next;
    logic [TENTH_W-1:0] open_tenths_reg,    open_tenths_next;
    logic               burst_flag_reg,     burst_flag_next;
    logic               valve_state_reg,    valve_state_next;
    logic               second_pending_reg, second_pending_next;
    logic               tenth_pending_reg,  tenth_pending_next;

    logic               frozen;
    logic [THR_W-1:0]   threshold;
    logic [TENTH_W-1:0] open_limit;
    logic [WORK_W-1:0]  work_cnt;

    assign frozen = (cfg.unit_style == STYLE_NO_CBD_A) ||
                    (cfg.unit_style == STYLE_NO_CBD_B) ||
                    (item.run_mode == MODE_MANUAL);
    assign threshold  = THR_W'(cfg.delay_minutes) * SECONDS_PER_MINUTE;
    assign open_limit = TENTH_W'(cfg.open_seconds) * TENTHS_PER_SECOND;

    always_comb
    begin
        second_pending_next = second_pending_reg | item.second_pulse;
        tenth_pending_next  = tenth_pending_reg  | item.tenth_pulse;
        work_seconds_next   = work_seconds_reg;
        open_tenths_next    = open_tenths_reg;
        burst_flag_next     = burst_flag_reg;
        valve_state_next    = valve_state_reg;
        work_cnt            = work_seconds_reg;

        if (!frozen)
        begin
            if ((item.run_mode == MODE_RUNNING) && item.flame_on && second_pending_next)
            begin
                if (work_cnt != WORK_MAX)
                    work_cnt = work_cnt + 1'b1;
                second_pending_next = 1'b0;
            end
            work_seconds_next = work_cnt;

            if (work_cnt >= WORK_W'(threshold))
            begin
                work_seconds_next = '0;
                open_tenths_next  = '0;
                burst_flag_next   = 1'b1;
            end

            if (burst_flag_next)
            begin
                if (open_tenths_next < open_limit)
                begin
                    valve_state_next = item.pump_running;
                    if (item.pump_running && tenth_pending_next)
                    begin
                        tenth_pending_next = 1'b0;
                        open_tenths_next   = open_tenths_next + 1'b1;
                    end
                end
                else
                begin
                    burst_flag_next = 1'b0;
                end
            end
            else
            begin
                open_tenths_next = '0;
                valve_state_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_seconds_reg   <= '0;
            open_tenths_reg    <= '0;
            burst_flag_reg     <= 1'b0;
            valve_state_reg    <= 1'b0;
            second_pending_reg <= 1'b0;
            tenth_pending_reg  <= 1'b0;
        end
        else if (step)
        begin
            work_seconds_reg   <= work_seconds_next;
            open_tenths_reg    <= open_tenths_next;
            burst_flag_reg     <= burst_flag_next;
            valve_state_reg    <= valve_state_next;
            second_pending_reg <= second_pending_next;
            tenth_pending_reg  <= tenth_pending_next;
        end
    end

    assign result.valve_open   = valve_state_next;
    assign result.burst_active = burst_flag_next;

endmodule

@@ hw/rtl/continuous_blowdown_valve_timer.sv @@
// Continuous blowdown valve timer.
//
// Channels: item (sink) takes one control pass per beat: run mode, flame,
// pump and the 1 s / 100 ms tick pulses. result (source) gives one beat per
// item: the valve command and the burst flag after that pass. cfg (sink)
// writes delay_minutes (index 0), open_seconds (1), unit_style (2); other
// indexes are ignored. cfg.ready is always high; write only while idle.
//
// Path: an item beat is captured by the input register, then the update
// logic writes the result register. One item per cycle while result.ready
// is high; the state update is a single pass through cbvt_core.
//
// Reset: all counters, flags, pending ticks and configuration registers go to
// zero, valve closed, both pipeline registers empty.
//
// Stall: when result.ready is low the result register holds, the input
// register holds its item, and item.ready drops once both are full. No beat
// is lost; state only advances when an item moves into the result register.
module continuous_blowdown_valve_timer (
    input logic         clk,
    input logic         rst_n,
    cbvt_item_if.sink   item,
    cbvt_result_if.source result,
    cbvt_cfg_if.sink    cfg
);
    import cbvt_pkg::*;

    cbvt_cfg_t    cfg_val;
    cbvt_item_t   stage_reg;
    logic         stage_valid_reg;
    cbvt_result_t res_reg;
    cbvt_result_t res_next;
    logic         res_valid_reg;
    logic         advance;
    logic         in_beat;

    assign cfg.ready = 1'b1;

    cbvt_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    // stage moves on when the result slot is free or being drained
    assign advance    = stage_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !stage_valid_reg || advance;
    assign in_beat    = item.valid && item.ready;

    cbvt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_reg),
        .cfg    (cfg_val),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_beat)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            stage_reg.run_mode     <= item.run_mode;
            stage_reg.flame_on     <= item.flame_on;
            stage_reg.second_pulse <= item.second_pulse;
            stage_reg.tenth_pulse  <= item.tenth_pulse;
            stage_reg.pump_running <= item.pump_running;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign result.valid        = res_valid_reg;
    assign result.valve_open   = res_reg.valve_open;
    assign result.burst_active = res_reg.burst_active;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import cbvt_pkg::*;

    // idle run modes; the package names only running and manual
    localparam logic [1:0] MODE_IDLE_LO = 2'd0;
    localparam logic [1:0] MODE_IDLE_HI = 2'd1;
    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned MAX_WAIT     = 5;
    localparam int unsigned MAX_REPORTS  = 40;

    logic clk;
    logic rst_n;

    cbvt_item_if   item_ch();
    cbvt_result_if res_ch();
    cbvt_cfg_if    cfg_ch();

    continuous_blowdown_valve_timer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the block: register values and timer state
    // ------------------------------------------------------------------
    logic [7:0]         cfg_delay;
    logic [7:0]         cfg_open;
    logic [1:0]         cfg_style;
    logic [WORK_W-1:0]  burner_secs;
    logic [TENTH_W-1:0] valve_tenths;
    logic               in_burst;
    logic               valve_cmd;
    logic               sec_pend;
    logic               tenth_pend;

    // Expected valve/burst beats, oldest first
    cbvt_result_t valve_expect_q[$];
    // Control passes waiting to be driven
    cbvt_item_t   pass_q[$];

    int unsigned passes_queued;
    int unsigned results_seen;
    int unsigned settings_used;
    int unsigned bursts_started;
    int unsigned valve_open_seen;
    int unsigned mismatches;
    int unsigned cycles;

    // driver/monitor handoff flags (set at posedge, consumed at negedge)
    logic        item_sent;
    cbvt_item_t  taken_pass;
    int unsigned src_wait;
    logic        src_steady;
    logic        result_taken;
    int unsigned snk_wait;
    logic        snk_steady;

    // One control pass of the timer: latch ticks, count burner seconds,
    // run the burst. Returns the valve command and burst flag after it.
    function automatic cbvt_result_t blowdown_pass(cbvt_item_t p);
        cbvt_result_t       r;
        logic [THR_W-1:0]   threshold;
        logic [TENTH_W-1:0] open_limit;
        // ticks latch on every pass, frozen or not
        if (p.second_pulse)
            sec_pend = 1'b1;
        if (p.tenth_pulse)
            tenth_pend = 1'b1;
        if (cfg_style != STYLE_NO_CBD_A && cfg_style != STYLE_NO_CBD_B
                && p.run_mode != MODE_MANUAL)
        begin
            threshold  = THR_W'(cfg_delay) * SECONDS_PER_MINUTE;
            open_limit = TENTH_W'(cfg_open) * TENTHS_PER_SECOND;
            if (p.run_mode == MODE_RUNNING && p.flame_on && sec_pend)
            begin
                if (burner_secs != WORK_MAX)
                    burner_secs = burner_secs + 1'b1;
                sec_pend = 1'b0;
            end
            // delay of zero meets the threshold every pass
            if (burner_secs >= WORK_W'(threshold))
            begin
                burner_secs  = '0;
                valve_tenths = '0;
                in_burst     = 1'b1;
                bursts_started++;
            end
            if (in_burst)
            begin
                if (valve_tenths < open_limit)
                begin
                    if (p.pump_running)
                    begin
                        valve_cmd = 1'b1;
                        if (tenth_pend)
                        begin
                            tenth_pend   = 1'b0;
                            valve_tenths = valve_tenths + 1'b1;
                        end
                    end
                    else
                    begin
                        // pump stopped: close, leave the tenth pending
                        valve_cmd = 1'b0;
                    end
                end
                else
                begin
                    // burst over; valve keeps its command for this pass
                    in_burst = 1'b0;
                end
            end
            else
            begin
                valve_tenths = '0;
                valve_cmd    = 1'b0;
            end
        end
        r.valve_open   = valve_cmd;
        r.burst_active = in_burst;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic int unsigned draw_wait(input logic steady);
        return steady ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // ------------------------------------------------------------------
    // Item driver: present passes from pass_q at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            taken_pass.run_mode     = item_ch.run_mode;
            taken_pass.flame_on     = item_ch.flame_on;
            taken_pass.second_pulse = item_ch.second_pulse;
            taken_pass.tenth_pulse  = item_ch.tenth_pulse;
            taken_pass.pump_running = item_ch.pump_running;
            item_sent = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        cbvt_item_t nxt;
        if (rst_n)
        begin
            if (item_sent)
            begin
                // predict at the negedge so the monitor never races the push
                valve_expect_q.push_back(blowdown_pass(taken_pass));
                item_sent = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    src_steady = ~src_steady;
                src_wait = draw_wait(src_steady);
            end
            if (!item_ch.valid || taken_pass_freed())
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    item_ch.valid <= 1'b0;
                end
                else if (pass_q.size() > 0)
                begin
                    nxt = pass_q.pop_front();
                    item_ch.valid        <= 1'b1;
                    item_ch.run_mode     <= nxt.run_mode;
                    item_ch.flame_on     <= nxt.flame_on;
                    item_ch.second_pulse <= nxt.second_pulse;
                    item_ch.tenth_pulse  <= nxt.tenth_pulse;
                    item_ch.pump_running <= nxt.pump_running;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // the beat on the bus was taken at the last posedge
    logic beat_gone;
    always @(posedge clk)
        beat_gone = rst_n && item_ch.valid && item_ch.ready;

    function automatic logic taken_pass_freed();
        return beat_gone;
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: random backpressure, compare against predictions
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cbvt_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            result_taken = 1'b1;
            if (valve_expect_q.size() == 0)
                report_mismatch($sformatf("result beat %0d with nothing expected",
                                          results_seen));
            else
            begin
                want = valve_expect_q.pop_front();
                if (res_ch.valve_open !== want.valve_open)
                    report_mismatch($sformatf("beat %0d valve_open %b, want %b",
                                              results_seen, res_ch.valve_open,
                                              want.valve_open));
                if (res_ch.burst_active !== want.burst_active)
                    report_mismatch($sformatf("beat %0d burst_active %b, want %b",
                                              results_seen, res_ch.burst_active,
                                              want.burst_active));
                if (want.valve_open)
                    valve_open_seen++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (result_taken)
        begin
            result_taken = 1'b0;
            if ($urandom_range(0, 49) == 0)
                snk_steady = ~snk_steady;
            snk_wait = draw_wait(snk_steady);
        end
        if (rst_n && snk_wait > 0)
        begin
            snk_wait--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= rst_n;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic cbvt_item_t mk_pass(input logic [1:0] mode, input logic flame,
                                           input logic sec, input logic tenth,
                                           input logic pump);
        cbvt_item_t p;
        p.run_mode     = mode;
        p.flame_on     = flame;
        p.second_pulse = sec;
        p.tenth_pulse  = tenth;
        p.pump_running = pump;
        return p;
    endfunction

    // Mostly a burner that runs with flame and pump, ticks at random;
    // noisy passes draw every field uniformly.
    function automatic cbvt_item_t random_pass(input logic noisy);
        cbvt_item_t  p;
        int unsigned pick;
        if (noisy)
        begin
            p.run_mode     = 2'($urandom_range(0, 3));
            p.flame_on     = 1'($urandom_range(0, 1));
            p.pump_running = 1'($urandom_range(0, 1));
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 84)
                p.run_mode = MODE_RUNNING;
            else if (pick < 90)
                p.run_mode = MODE_MANUAL;
            else if (pick < 95)
                p.run_mode = MODE_IDLE_LO;
            else
                p.run_mode = MODE_IDLE_HI;
            p.flame_on     = $urandom_range(0, 99) < 92;
            p.pump_running = $urandom_range(0, 99) < 85;
        end
        p.second_pulse = 1'($urandom_range(0, 1));
        p.tenth_pulse  = 1'($urandom_range(0, 1));
        return p;
    endfunction

    task automatic queue_pass(input cbvt_item_t p);
        pass_q.push_back(p);
        passes_queued++;
    endtask

    // wait until every queued pass has come back as a result beat
    task automatic await_drain();
        while (results_seen != passes_queued)
            @(negedge clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_DELAY_MINUTES: cfg_delay = val;
            REG_OPEN_SECONDS:  cfg_open  = val;
            REG_UNIT_STYLE:    cfg_style = val[1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_all(input logic [7:0] delay, input logic [7:0] open_s,
                           input logic [1:0] style);
        await_drain();
        write_setting(REG_DELAY_MINUTES, delay);
        write_setting(REG_OPEN_SECONDS, open_s);
        write_setting(REG_UNIT_STYLE, CFG_DATA_W'(style));
        settings_used++;
    endtask

    task automatic run_phase(input logic [7:0] delay, input logic [7:0] open_s,
                             input logic [1:0] style, input int unsigned n);
        set_all(delay, open_s, style);
        for (int unsigned i = 0; i < n; i++)
            queue_pass(random_pass($urandom_range(0, 9) == 0));
    endtask

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.run_mode     = MODE_IDLE_LO;
        item_ch.flame_on     = 1'b0;
        item_ch.second_pulse = 1'b0;
        item_ch.tenth_pulse  = 1'b0;
        item_ch.pump_running = 1'b0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_DELAY_MINUTES;
        cfg_ch.data   = '0;
        cfg_delay = '0;
        cfg_open  = '0;
        cfg_style = '0;
        burner_secs  = '0;
        valve_tenths = '0;
        in_burst   = 1'b0;
        valve_cmd  = 1'b0;
        sec_pend   = 1'b0;
        tenth_pend = 1'b0;
        passes_queued   = 0;
        results_seen    = 0;
        settings_used   = 1;
        bursts_started  = 0;
        valve_open_seen = 0;
        mismatches   = 0;
        item_sent    = 1'b0;
        beat_gone    = 1'b0;
        result_taken = 1'b0;
        src_wait   = 0;
        snk_wait   = 0;
        src_steady = 1'b0;
        snk_steady = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, all-zero and all-one passes, manual freeze
        queue_pass(mk_pass(MODE_IDLE_LO, 0, 0, 0, 0));
        queue_pass(mk_pass(MODE_RUNNING, 1, 1, 1, 1));
        queue_pass(mk_pass(MODE_MANUAL, 1, 1, 1, 1));
        queue_pass(mk_pass(MODE_IDLE_HI, 0, 1, 0, 1));

        // zero delay restarts the burst each pass; pump drop closes the valve
        // and keeps the tenth pending until the pump runs again
        set_all(8'd0, 8'd2, 2'd0);
        queue_pass(mk_pass(MODE_RUNNING, 1, 1, 1, 1));
        queue_pass(mk_pass(MODE_RUNNING, 1, 0, 1, 0));
        queue_pass(mk_pass(MODE_RUNNING, 1, 0, 0, 1));
        queue_pass(mk_pass(MODE_MANUAL, 0, 0, 1, 0));
        queue_pass(mk_pass(MODE_RUNNING, 0, 0, 0, 1));

        // write to an unmapped index, then both disabling styles
        await_drain();
        write_setting(REG_UNUSED, 8'hFF);
        write_setting(REG_UNIT_STYLE, CFG_DATA_W'(STYLE_NO_CBD_A));
        queue_pass(mk_pass(MODE_RUNNING, 1, 1, 1, 0));
        queue_pass(mk_pass(MODE_RUNNING, 1, 0, 0, 1));
        await_drain();
        write_setting(REG_UNIT_STYLE, CFG_DATA_W'(STYLE_NO_CBD_B));
        queue_pass(mk_pass(MODE_RUNNING, 1, 1, 1, 1));

        // zero open time: burst starts and ends on the same pass
        set_all(8'd0, 8'd0, 2'd2);
        queue_pass(mk_pass(MODE_RUNNING, 1, 1, 1, 1));
        queue_pass(mk_pass(MODE_IDLE_LO, 0, 0, 0, 0));

        // top of both ranges
        set_all(8'd255, 8'd255, 2'd0);
        queue_pass(mk_pass(MODE_RUNNING, 1, 1, 1, 1));
        queue_pass(mk_pass(MODE_RUNNING, 0, 1, 1, 1));

        // random phases; short delays so full bursts happen often
        run_phase(8'd1,   8'd1,   2'd0, 400);
        run_phase(8'd1,   8'd3,   2'd2, 350);
        run_phase(8'd0,   8'd2,   2'd0, 150);
        run_phase(8'd255, 8'd255, 2'd0, 80);
        run_phase(8'd0,   8'd255, 2'd2, 100);
        run_phase(8'd2,   8'd1,   2'd0, 350);
        run_phase(8'd1,   8'd0,   STYLE_NO_CBD_A, 80);
        run_phase(8'd1,   8'd0,   STYLE_NO_CBD_B, 80);
        run_phase(8'd1,   8'd0,   2'd0, 200);

        await_drain();
        // let the bench idle on to catch any stray beat
        repeat (8) @(posedge clk);
        if (valve_expect_q.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      valve_expect_q.size()));

        $display("checked %0d control passes across %0d register settings",
                 results_seen, settings_used);
        $display("%0d bursts started, %0d beats with the valve open",
                 bursts_started, valve_open_seen);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/cbvt_pkg.sv
hw/rtl/cbvt_if.sv
hw/rtl/cbvt_cfg_regs.sv
hw/rtl/cbvt_core.sv
hw/rtl/continuous_blowdown_valve_timer.sv
tb/sv/tb.sv
